// ===== design/rarg_pkg.sv =====
// Shared widths, codes and types for the random-access recovery gate.
package rarg_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned DelayW  = 7;
  localparam int unsigned KindW   = 2;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned MaxFnW  = 17;
  localparam int unsigned PocW    = 32;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned InDataW = 128;
  localparam int unsigned OutDataW = 8;

  // Width of the modulo operands: frame sum and modulus are both 17 bits.
  localparam int unsigned DivW   = 17;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  localparam logic [OpW-1:0] OP_FLUSH  = 2'd0;
  localparam logic [OpW-1:0] OP_SEARCH = 2'd1;
  localparam logic [OpW-1:0] OP_FRAME  = 2'd2;

  localparam logic [KindW-1:0] KIND_NONE = 2'd0;
  localparam logic [KindW-1:0] KIND_I    = 2'd1;
  localparam logic [KindW-1:0] KIND_SEI  = 2'd2;
  localparam logic [KindW-1:0] KIND_IDR  = 2'd3;

  localparam logic [ModeW-1:0] MODE_DONE       = 3'd0;
  localparam logic [ModeW-1:0] MODE_SEARCH     = 3'd1;
  localparam logic [ModeW-1:0] MODE_COUNTING   = 3'd2;
  localparam logic [ModeW-1:0] MODE_WAIT_FRAME = 3'd3;
  localparam logic [ModeW-1:0] MODE_WAIT_POC   = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/rarg_div.sv =====
// Iterative restoring modulo unit, one quotient bit per cycle.
module rarg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rarg_pkg::DivW-1:0]    dividend_i,
  input  logic [rarg_pkg::DivW-1:0]    divisor_i,
  output rarg_pkg::div_status_t        status_o,
  output logic [rarg_pkg::DivW-1:0]    rem_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [rarg_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [rarg_pkg::DivW-1:0]      num_q, num_d;
  logic [rarg_pkg::DivW-1:0]      den_q, den_d;
  logic [rarg_pkg::DivW-1:0]      rem_q, rem_d;
  logic [rarg_pkg::DivW:0]        trial;
  logic [rarg_pkg::DivW:0]        diff;

  assign trial = {rem_q, num_q[rarg_pkg::DivW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rarg_pkg::DivCntW'(rarg_pkg::DivW);
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit is dropped safely
      rem_d = (trial >= {1'b0, den_q}) ? diff[rarg_pkg::DivW-1:0]
                                       : trial[rarg_pkg::DivW-1:0];
      num_d = {num_q[rarg_pkg::DivW-2:0], 1'b0};
      cnt_d = cnt_q - rarg_pkg::DivCntW'(1);
      if (cnt_q == rarg_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

// ===== design/h264_random_access_recovery_gate_top.sv =====
// Top level of the random-access recovery gate: stream ports, sequencer, state.
// Flush, search and unused opcodes go from transfer to the finish step; frame events
// that compute the target frame pass through accept, 17 modulo steps, a handover and
// finish. The finish step waits while the output stalls. One item at a time: a new
// item is taken only once the last is finished. Reset (async, active low) puts the gate in
// search mode with target frame and thread delay cleared and no result pending.
module h264_random_access_recovery_gate_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low bit up: thread_count[6:0], recovery_kind[8:7], sei_frame_count[24:9],
  // max_frame_num[41:25], frame_num[57:42], poc_decoded[89:58], poc_output[121:90],
  // zero fill [127:122]
  input  logic [rarg_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [rarg_pkg::OpW-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, low bit up: accept_data[0], suppress_picture[1], recovery_state[4:2],
  // zero fill [7:5]
  output logic [rarg_pkg::OutDataW-1:0]  m_axis_tdata
);

  // Sequencer: wait for a transfer, run the modulo unit if needed, then finish the step.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Item held for the duration of its processing
  logic [rarg_pkg::OpW-1:0]     op_q;
  logic [rarg_pkg::DelayW-1:0]  cnt_in_q;
  logic [rarg_pkg::KindW-1:0]   kind_q;
  logic [rarg_pkg::FrameW-1:0]  sei_q;
  logic [rarg_pkg::FrameW-1:0]  fnum_q;
  logic [rarg_pkg::MaxFnW-1:0]  maxfn_q;
  logic signed [rarg_pkg::PocW-1:0] poc_dec_q;
  logic signed [rarg_pkg::PocW-1:0] poc_out_q;
  logic                         did_div_q;

  // Architectural state
  logic [rarg_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [rarg_pkg::FrameW-1:0]  target_q, target_d;
  logic [rarg_pkg::DelayW-1:0]  delay_q, delay_d;
  logic signed [rarg_pkg::PocW-1:0] tpoc_q, tpoc_d;

  // Output register
  logic                         m_valid_q;
  logic [rarg_pkg::OutDataW-1:0] m_data_q, m_data_d;

  // Input field views
  logic [rarg_pkg::DelayW-1:0]  in_cnt;
  logic [rarg_pkg::KindW-1:0]   in_kind;
  logic [rarg_pkg::FrameW-1:0]  in_sei;
  logic [rarg_pkg::MaxFnW-1:0]  in_maxfn;
  logic [rarg_pkg::FrameW-1:0]  in_fnum;
  logic [rarg_pkg::PocW-1:0]    in_poc_dec;
  logic [rarg_pkg::PocW-1:0]    in_poc_out;

  logic                         in_xfer;
  logic                         need_div;
  logic                         out_free;
  logic                         fin_fire;
  logic                         acc_bit, sup_bit;
  logic [rarg_pkg::ModeW-1:0]   m_a;
  logic [rarg_pkg::FrameW-1:0]  tf_a;
  logic signed [rarg_pkg::PocW-1:0] poc_a;

  rarg_pkg::div_status_t        div_st;
  logic [rarg_pkg::DivW-1:0]    div_rem;
  logic [rarg_pkg::DivW-1:0]    div_num;

  assign in_cnt     = s_axis_tdata[6:0];
  assign in_kind    = s_axis_tdata[8:7];
  assign in_sei     = s_axis_tdata[24:9];
  assign in_maxfn   = s_axis_tdata[41:25];
  assign in_fnum    = s_axis_tdata[57:42];
  assign in_poc_dec = s_axis_tdata[89:58];
  assign in_poc_out = s_axis_tdata[121:90];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Target frame recomputation only runs when the thread delay has expired,
  // the modulus is known and the gate is still searching or counting.
  assign need_div = (s_axis_tuser == rarg_pkg::OP_FRAME) &&
                    (delay_q <= rarg_pkg::DelayW'(1)) &&
                    (in_maxfn != '0) &&
                    ((mode_q == rarg_pkg::MODE_SEARCH) || (mode_q == rarg_pkg::MODE_COUNTING));

  assign div_num = {1'b0, target_q} + {1'b0, in_fnum};

  rarg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer && need_div),
    .dividend_i (div_num),
    .divisor_i  (in_maxfn),
    .status_o   (div_st),
    .rem_o      (div_rem)
  );

  assign out_free = !m_valid_q || m_axis_tready;
  assign fin_fire = (state_q == ST_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (div_st.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Finishing step: all state updates of the item happen here.
  always_comb begin
    mode_d   = mode_q;
    target_d = target_q;
    delay_d  = delay_q;
    tpoc_d   = tpoc_q;
    acc_bit  = 1'b0;
    sup_bit  = 1'b0;
    m_a      = mode_q;
    tf_a     = target_q;
    poc_a    = tpoc_q;
    case (op_q)
      rarg_pkg::OP_FLUSH: begin
        mode_d   = rarg_pkg::MODE_SEARCH;
        target_d = '0;
        delay_d  = cnt_in_q;
      end
      rarg_pkg::OP_SEARCH: begin
        acc_bit = 1'b1;
        if (mode_q == rarg_pkg::MODE_SEARCH) begin
          case (kind_q)
            rarg_pkg::KIND_IDR: mode_d = rarg_pkg::MODE_DONE;
            rarg_pkg::KIND_SEI: begin
              target_d = sei_q;
              mode_d   = rarg_pkg::MODE_COUNTING;
            end
            rarg_pkg::KIND_I: begin
              target_d = '0;
              mode_d   = rarg_pkg::MODE_COUNTING;
            end
            default: acc_bit = 1'b0;
          endcase
        end
      end
      rarg_pkg::OP_FRAME: begin
        if (delay_q > rarg_pkg::DelayW'(1)) begin
          delay_d = delay_q - rarg_pkg::DelayW'(1);
        end else if ((mode_q != rarg_pkg::MODE_DONE) && (maxfn_q != '0)) begin
          if (did_div_q) begin
            m_a  = rarg_pkg::MODE_WAIT_FRAME;
            tf_a = div_rem[rarg_pkg::FrameW-1:0];
          end
          if ((m_a == rarg_pkg::MODE_WAIT_FRAME) && (tf_a <= fnum_q)) begin
            m_a   = rarg_pkg::MODE_WAIT_POC;
            poc_a = poc_dec_q;
          end
          if ((m_a == rarg_pkg::MODE_WAIT_POC) && (poc_out_q >= poc_a)) begin
            m_a = rarg_pkg::MODE_DONE;
          end
          mode_d   = m_a;
          target_d = tf_a;
          tpoc_d   = poc_a;
          sup_bit  = (m_a != rarg_pkg::MODE_DONE);
        end
      end
      default: ;
    endcase
    m_data_d = {3'b000, mode_d, sup_bit, acc_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= rarg_pkg::MODE_SEARCH;
      target_q  <= '0;
      delay_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        mode_q    <= mode_d;
        target_q  <= target_d;
        delay_q   <= delay_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= s_axis_tuser;
      cnt_in_q  <= in_cnt;
      kind_q    <= in_kind;
      sei_q     <= in_sei;
      maxfn_q   <= in_maxfn;
      fnum_q    <= in_fnum;
      poc_dec_q <= in_poc_dec;
      poc_out_q <= in_poc_out;
      did_div_q <= need_div;
    end
    if (fin_fire) begin
      tpoc_q   <= tpoc_d;
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The modulo unit only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_DIV))
    else $error("modulo result outside division state");

  // Mode never leaves the defined range
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= rarg_pkg::MODE_WAIT_POC)
    else $error("recovery mode out of range");

  // A finished step presents its result and frees the input side
  a_fin_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> (m_valid_q && (state_q == ST_IDLE)))
    else $error("finished step did not reach the output register");

  // Modulo unit is idle whenever a new item can be taken
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_st.busy)
    else $error("input ready while modulo unit busy");

endmodule
